// ===== sv/ate_pkg.sv =====
// Shared command codes, status codes and compare flags for the array table engine.
`default_nettype none

package ate_pkg;

   localparam int DATA_W = 32;

   localparam logic [3:0] OP_APPEND  = 4'd0;
   localparam logic [3:0] OP_INSERT  = 4'd1;
   localparam logic [3:0] OP_REMOVE  = 4'd2;
   localparam logic [3:0] OP_LSEARCH = 4'd3;
   localparam logic [3:0] OP_BSEARCH = 4'd4;
   localparam logic [3:0] OP_GET     = 4'd5;
   localparam logic [3:0] OP_MAX     = 4'd6;
   localparam logic [3:0] OP_MIN     = 4'd7;
   localparam logic [3:0] OP_SUM     = 4'd8;
   localparam logic [3:0] OP_REVERSE = 4'd9;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_BAD_INDEX = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic eq;
      logic gt;
      logic lt;
   } alu_flags_type;

endpackage

`default_nettype wire

// ===== sv/ate_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ate_alu.sv =====
// Shared 32-bit unit: wrapping add and signed compare of a stored word against a key or accumulator.
`default_nettype none

module ate_alu
   import ate_pkg::*;
(
   input  logic signed [DATA_W-1:0] opa,
   input  logic signed [DATA_W-1:0] opb,
   output logic        [DATA_W-1:0] sum,
   output alu_flags_type            flags
);

   assign sum      = DATA_W'(opa + opb);
   assign flags.eq = (opa == opb);
   assign flags.gt = (opa > opb);
   assign flags.lt = (opa < opb);

endmodule

`default_nettype wire

// ===== sv/array_table_engine_core.sv =====
// Bounded list engine: up to MAX_ENTRIES signed 32-bit words in one RAM, with a fill count.
// One command is taken at a time; req_stall stays high from the transfer until the result is
// queued in the output register, which frees the input while a result still waits. The RAM has
// one read and one write port; scans and shifts walk it through that read port one word a
// cycle: remove and insert move each shifted entry one place, linear search, max, min and sum
// read the entries below the count (search ends at the first hit), binary search reads one
// word per probe, and reverse holds the low word, fetches the high word and writes both back.
// The entries are not cleared at reset; only positions below the count are ever read.
// The capacity register (reset 256) may be written only while no command is in flight.
`default_nettype none

module array_table_engine_core
   import ate_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [3:0]               req_op,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [7:0]               req_index,
   input  logic [7:0]               req_range_low,
   input  logic [7:0]               req_range_high,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data_out,
   output logic [7:0]               rsp_found_index,
   output logic [8:0]               rsp_count,
   // capacity register
   input  logic                     csr_wr_en,
   input  logic [8:0]               csr_wr_data
);

   localparam int AW  = $clog2(MAX_ENTRIES);
   localparam int AW1 = AW + 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int XW  = (CW > 9) ? CW : 9;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_SHUP   = 4'd2;
   localparam logic [3:0] S_SHDN   = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_BPROBE = 4'd5;
   localparam logic [3:0] S_BCMP   = 4'd6;
   localparam logic [3:0] S_GETW   = 4'd7;
   localparam logic [3:0] S_REV1   = 4'd8;
   localparam logic [3:0] S_REV2   = 4'd9;
   localparam logic [3:0] S_REV3   = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   // control registers
   logic [3:0]        state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [8:0]        cap_ff, cap_in;
   logic              pend_ff, pend_in;
   logic              iss_ff, iss_in;

   // command and working registers
   logic [3:0]        op_ff, op_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [7:0]        idx_ff, idx_in;
   logic [7:0]        rlo_ff, rlo_in;
   logic [7:0]        rhi_ff, rhi_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     ptr2_ff, ptr2_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [2:0]        st_ff, st_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [7:0]        found_ff, found_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   logic signed [9:0] lo_ff, lo_in;
   logic signed [9:0] hi_ff, hi_in;

   // result register
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [7:0]        rsp_found_ff, rsp_found_in;
   logic [CW-1:0]     rsp_count_ff, rsp_count_in;

   // RAM port
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata, rd_data;

   // shared unit
   logic [DATA_W-1:0] alu_b, alu_sum;
   alu_flags_type     alu_flags;

   // derived values
   logic [XW-1:0]     cnt_x, cap_x, limit_x, idx_x, cnt_m1;
   logic              is_full;
   logic [9:0]        mid_sum;
   logic [8:0]        mid;
   logic              rev_more;

   assign cnt_x    = XW'(count_ff);
   assign cap_x    = XW'(cap_ff);
   assign limit_x  = (cap_x < XW'(MAX_ENTRIES)) ? cap_x : XW'(MAX_ENTRIES);
   assign idx_x    = XW'(idx_ff);
   assign cnt_m1   = cnt_x - XW'(1);
   assign is_full  = (cnt_x >= limit_x);
   assign mid_sum  = 10'(lo_ff + hi_ff);
   assign mid      = mid_sum[9:1];
   assign rev_more = (AW1'(ptr_ff) + AW1'(2)) < AW1'(ptr2_ff);

   assign alu_b = (op_ff == OP_LSEARCH || op_ff == OP_BSEARCH) ? val_ff : acc_ff;

   ate_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   ate_alu u_alu (
      .opa   (rd_data),
      .opb   (alu_b),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      pend_in       = pend_ff;
      iss_in        = iss_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      rlo_in        = rlo_ff;
      rhi_in        = rhi_ff;
      ptr_in        = ptr_ff;
      ptr2_in       = ptr2_ff;
      rd_idx_in     = rd_idx_ff;
      st_in         = st_ff;
      data_in       = data_ff;
      found_in      = found_ff;
      acc_in        = acc_ff;
      tmp_in        = tmp_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      // drop the result once the transfer completes
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               val_in   = req_value;
               idx_in   = req_index;
               rlo_in   = req_range_low;
               rhi_in   = req_range_high;
               state_in = S_START;
            end
         end

         S_START: begin
            st_in    = ST_OK;
            data_in  = '0;
            found_in = '0;
            acc_in   = '0;
            pend_in  = 1'b0;
            iss_in   = 1'b1;
            ptr_in   = '0;
            state_in = S_DONE;
            case (op_ff)
               OP_APPEND: begin
                  if (is_full) begin
                     st_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(count_ff);
                     mem_wdata = val_ff;
                     count_in  = count_ff + CW'(1);
                  end
               end
               OP_INSERT: begin
                  if (is_full) begin
                     st_in = ST_FULL;
                  end else if (idx_x > cnt_x) begin
                     st_in = ST_BAD_INDEX;
                  end else if (idx_x == cnt_x) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(idx_ff);
                     mem_wdata = val_ff;
                     count_in  = count_ff + CW'(1);
                  end else begin
                     ptr_in   = AW'(cnt_m1);
                     state_in = S_SHUP;
                  end
               end
               OP_REMOVE: begin
                  if (idx_x >= cnt_x) begin
                     st_in = ST_BAD_INDEX;
                  end else if (idx_x == cnt_m1) begin
                     count_in = count_ff - CW'(1);
                  end else begin
                     ptr_in   = AW'(idx_x + XW'(1));
                     state_in = S_SHDN;
                  end
               end
               OP_LSEARCH: begin
                  if (count_ff == '0) begin
                     st_in = ST_NOT_FOUND;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               OP_BSEARCH: begin
                  if (count_ff == '0) begin
                     st_in = ST_NOT_FOUND;
                  end else begin
                     lo_in    = 10'(rlo_ff);
                     hi_in    = (XW'(rhi_ff) > cnt_m1) ? 10'(cnt_m1) : 10'(rhi_ff);
                     state_in = S_BPROBE;
                  end
               end
               OP_GET: begin
                  if (idx_x >= cnt_x) begin
                     st_in = ST_BAD_INDEX;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(idx_ff);
                     state_in  = S_GETW;
                  end
               end
               OP_MAX, OP_MIN: begin
                  if (count_ff == '0) begin
                     st_in = ST_EMPTY;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               OP_SUM: begin
                  if (count_ff != '0) begin
                     state_in = S_SCAN;
                  end
               end
               OP_REVERSE: begin
                  if (cnt_x >= XW'(2)) begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     ptr2_in   = AW'(cnt_m1);
                     state_in  = S_REV1;
                  end
               end
               default: begin
               end
            endcase
         end

         // shift up: read downward from the top, write each word one place higher
         S_SHUP: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(rd_idx_ff + 1'b1);
               mem_wdata = rd_data;
            end
            if (iss_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff;
               rd_idx_in = ptr_ff;
               pend_in   = 1'b1;
               if (XW'(ptr_ff) == idx_x) begin
                  iss_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(idx_ff);
                  mem_wdata = val_ff;
                  count_in  = count_ff + CW'(1);
                  state_in  = S_DONE;
               end
            end
         end

         // shift down: read upward past the removed slot, write each word one place lower
         S_SHDN: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(rd_idx_ff - 1'b1);
               mem_wdata = rd_data;
            end
            if (iss_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff;
               rd_idx_in = ptr_ff;
               pend_in   = 1'b1;
               if (XW'(ptr_ff) == cnt_m1) begin
                  iss_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end
         end

         S_SCAN: begin
            if (iss_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff;
               rd_idx_in = ptr_ff;
               pend_in   = 1'b1;
               if (XW'(ptr_ff) == cnt_m1) begin
                  iss_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               case (op_ff)
                  OP_LSEARCH: begin
                     if (alu_flags.eq) begin
                        found_in = 8'(rd_idx_ff);
                        state_in = S_DONE;
                     end
                  end
                  OP_MAX: begin
                     if (rd_idx_ff == '0 || alu_flags.gt) begin
                        acc_in = rd_data;
                     end
                  end
                  OP_MIN: begin
                     if (rd_idx_ff == '0 || alu_flags.lt) begin
                        acc_in = rd_data;
                     end
                  end
                  OP_SUM: begin
                     acc_in = alu_sum;
                  end
                  default: begin
                  end
               endcase
            end else if (!iss_ff) begin
               state_in = S_DONE;
               if (op_ff == OP_LSEARCH) begin
                  st_in = ST_NOT_FOUND;
               end else begin
                  data_in = acc_ff;
               end
            end
         end

         S_BPROBE: begin
            if (lo_ff > hi_ff) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = AW'(mid);
               rd_idx_in = AW'(mid);
               state_in  = S_BCMP;
            end
         end

         S_BCMP: begin
            state_in = S_BPROBE;
            if (alu_flags.eq) begin
               found_in = 8'(rd_idx_ff);
               state_in = S_DONE;
            end else if (alu_flags.gt) begin
               hi_in = 10'(rd_idx_ff) - 10'd1;
            end else begin
               lo_in = 10'(rd_idx_ff) + 10'd1;
            end
         end

         S_GETW: begin
            data_in  = rd_data;
            state_in = S_DONE;
         end

         // swap: hold the low word, fetch the high word, write both back
         S_REV1: begin
            tmp_in    = rd_data;
            mem_re    = 1'b1;
            mem_raddr = ptr2_ff;
            state_in  = S_REV2;
         end

         S_REV2: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rd_data;
            state_in  = S_REV3;
         end

         S_REV3: begin
            mem_we    = 1'b1;
            mem_waddr = ptr2_ff;
            mem_wdata = tmp_ff;
            if (rev_more) begin
               ptr_in    = ptr_ff + 1'b1;
               ptr2_in   = ptr2_ff - 1'b1;
               mem_re    = 1'b1;
               mem_raddr = ptr_ff + 1'b1;
               state_in  = S_REV1;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_data_in   = data_ff;
               rsp_found_in  = found_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= 9'd256;
         pend_ff      <= 1'b0;
         iss_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         iss_ff       <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      rlo_ff        <= rlo_in;
      rhi_ff        <= rhi_in;
      ptr_ff        <= ptr_in;
      ptr2_ff       <= ptr2_in;
      rd_idx_ff     <= rd_idx_in;
      st_ff         <= st_in;
      data_ff       <= data_in;
      found_ff      <= found_in;
      acc_ff        <= acc_in;
      tmp_ff        <= tmp_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_count       = 9'(rsp_count_ff);

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for array_table_engine_core: shadow list, command stream, result check.
module tb
   import ate_pkg::*;
;

   localparam int DEPTH         = 256;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int TIMEOUT_NS    = 40_000_000;

   localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
   localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

   localparam logic signed [31:0] WORD_MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MOST_POS = 32'sh7FFF_FFFF;

   typedef struct {
      logic [3:0]         op;
      logic [2:0]         status;
      logic signed [31:0] data;
      logic [7:0]         found;
      logic [8:0]         count;
   } list_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_op = '0;
   logic signed [31:0] req_value = '0;
   logic [7:0]         req_index = '0;
   logic [7:0]         req_range_low = '0;
   logic [7:0]         req_range_high = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_data_out;
   logic [7:0]         rsp_found_index;
   logic [8:0]         rsp_count;
   logic               csr_wr_en = 1'b0;
   logic [8:0]         csr_wr_data = '0;

   // shadow copy of the list and the capacity register
   logic signed [31:0] shadow_words [DEPTH];
   int                 shadow_count = 0;
   logic [8:0]         shadow_capacity = 9'd256;

   list_result_type    pending_results [$];
   int                 fail_count = 0;
   int                 burst_left = 0;
   logic               long_hold_req = 1'b0;

   array_table_engine_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_index       (req_index),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   initial begin
      #TIMEOUT_NS;
      $display("array_table_engine_core verification failed");
      $finish;
   end

   // Apply one command to the shadow list and return the result it must give.
   function automatic list_result_type apply_to_list(input logic [3:0] op,
                                                     input logic signed [31:0] value,
                                                     input logic [7:0] index,
                                                     input logic [7:0] rlo,
                                                     input logic [7:0] rhi);
      list_result_type    r;
      int                 limit;
      int                 i;
      int                 lo;
      int                 hi;
      int                 mid;
      logic signed [31:0] m;
      logic signed [31:0] t;
      logic [31:0]        acc;
      r.op     = op;
      r.status = ST_OK;
      r.data   = '0;
      r.found  = '0;
      limit    = (int'(shadow_capacity) < DEPTH) ? int'(shadow_capacity) : DEPTH;
      case (op)
         OP_APPEND: begin
            if (shadow_count >= limit) begin
               r.status = ST_FULL;
            end else begin
               shadow_words[shadow_count] = value;
               shadow_count++;
            end
         end
         OP_INSERT: begin
            // full wins over a bad index
            if (shadow_count >= limit) begin
               r.status = ST_FULL;
            end else if (int'(index) > shadow_count) begin
               r.status = ST_BAD_INDEX;
            end else begin
               for (i = shadow_count; i > int'(index); i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[index] = value;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            if (int'(index) >= shadow_count) begin
               r.status = ST_BAD_INDEX;
            end else begin
               for (i = int'(index); i + 1 < shadow_count; i++)
                  shadow_words[i] = shadow_words[i+1];
               shadow_count--;
            end
         end
         OP_LSEARCH: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_words[i] == value) begin
                  r.status = ST_OK;
                  r.found  = 8'(i);
                  break;
               end
            end
         end
         OP_BSEARCH: begin
            r.status = ST_NOT_FOUND;
            if (shadow_count > 0) begin
               lo = int'(rlo);
               hi = (int'(rhi) > shadow_count - 1) ? shadow_count - 1 : int'(rhi);
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  if (shadow_words[mid] > value) begin
                     hi = mid - 1;
                  end else if (shadow_words[mid] < value) begin
                     lo = mid + 1;
                  end else begin
                     r.status = ST_OK;
                     r.found  = 8'(mid);
                     break;
                  end
               end
            end
         end
         OP_GET: begin
            if (int'(index) >= shadow_count) r.status = ST_BAD_INDEX;
            else r.data = shadow_words[index];
         end
         OP_MAX, OP_MIN: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               m = shadow_words[0];
               for (i = 1; i < shadow_count; i++) begin
                  if (op == OP_MAX ? (shadow_words[i] > m) : (shadow_words[i] < m))
                     m = shadow_words[i];
               end
               r.data = m;
            end
         end
         OP_SUM: begin
            acc = '0;
            for (i = 0; i < shadow_count; i++)
               acc = acc + shadow_words[i];
            r.data = acc;
         end
         OP_REVERSE: begin
            for (i = 0; i < shadow_count / 2; i++) begin
               t = shadow_words[i];
               shadow_words[i] = shadow_words[shadow_count-1-i];
               shadow_words[shadow_count-1-i] = t;
            end
         end
         default: ;
      endcase
      r.count = 9'(shadow_count);
      return r;
   endfunction

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return WORD_MOST_NEG;
         1:       return WORD_MOST_POS;
         2:       return '0;
         3:       return -32'sd1;
         4, 5, 6: return 32'($urandom_range(0, 7)) - 32'sd4;
         default: return 32'($urandom);
      endcase
   endfunction

   // Mostly in or just past the stored range, now and then anywhere.
   function automatic logic [7:0] pick_index();
      int top;
      top = (shadow_count > 255) ? 255 : shadow_count;
      if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, top));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [8:0] pick_capacity();
      case ($urandom_range(0, 7))
         0:       return 9'd1;
         1:       return 9'd2;
         2:       return 9'd256;
         3:       return 9'($urandom_range(0, 511));
         default: return 9'($urandom_range(3, 40));
      endcase
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, what);
   endtask

   // Offer one command, hold it until the transfer, then record its expected result.
   task automatic send_cmd(input logic [3:0] op, input logic [31:0] value,
                           input logic [7:0] index, input logic [7:0] rlo,
                           input logic [7:0] rhi);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      = 1'b1;
      req_op         = op;
      req_value      = value;
      req_index      = index;
      req_range_low  = rlo;
      req_range_high = rhi;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_to_list(op, value, index, rlo, rhi));
   endtask

   // Drop valid and wait until every pending result has come back.
   task automatic wait_idle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [8:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      shadow_capacity = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic empty_list();
      while (shadow_count > 0)
         send_cmd(OP_REMOVE, $urandom, 8'($urandom_range(0, shadow_count - 1)), rnd8(), rnd8());
   endtask

   task automatic send_random_edit();
      int                 sel;
      logic [3:0]         op;
      logic signed [31:0] value;
      sel = $urandom_range(0, 99);
      if (sel < 15)      op = OP_APPEND;
      else if (sel < 30) op = OP_INSERT;
      else if (sel < 52) op = OP_REMOVE;
      else if (sel < 60) op = OP_LSEARCH;
      else if (sel < 65) op = OP_BSEARCH;
      else if (sel < 75) op = OP_GET;
      else if (sel < 79) op = OP_MAX;
      else if (sel < 83) op = OP_MIN;
      else if (sel < 87) op = OP_SUM;
      else if (sel < 94) op = OP_REVERSE;
      else               op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      value = pick_word();
      if ((op == OP_LSEARCH || op == OP_BSEARCH) && shadow_count > 0 && $urandom_range(0, 1))
         value = shadow_words[$urandom_range(0, shadow_count - 1)];
      send_cmd(op, value, pick_index(), rnd8(), rnd8());
   endtask

   // Every command but append and insert on an empty list, plus the first and last spare op codes.
   task automatic test_empty_list();
      send_cmd(OP_REMOVE, pick_word(), 8'd0, rnd8(), rnd8());
      send_cmd(OP_REMOVE, pick_word(), 8'd255, rnd8(), rnd8());
      send_cmd(OP_GET, pick_word(), 8'd0, rnd8(), rnd8());
      send_cmd(OP_MAX, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_MIN, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_SUM, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_REVERSE, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_LSEARCH, '0, rnd8(), rnd8(), rnd8());
      send_cmd(OP_BSEARCH, '0, rnd8(), 8'd0, 8'd255);
      send_cmd(OP_SPARE_FIRST, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_SPARE_LAST, pick_word(), rnd8(), rnd8(), rnd8());
   endtask

   task automatic test_list_edits();
      send_cmd(OP_APPEND, WORD_MOST_NEG, rnd8(), rnd8(), rnd8());
      send_cmd(OP_APPEND, WORD_MOST_POS, rnd8(), rnd8(), rnd8());
      send_cmd(OP_APPEND, '0, rnd8(), rnd8(), rnd8());
      send_cmd(OP_INSERT, -32'sd1, 8'd0, rnd8(), rnd8());
      // insert at the count appends, one past it is a bad index
      send_cmd(OP_INSERT, 32'sd5, 8'd4, rnd8(), rnd8());
      send_cmd(OP_INSERT, 32'sd7, 8'd6, rnd8(), rnd8());
      send_cmd(OP_INSERT, 32'sd3, 8'd2, rnd8(), rnd8());
      send_cmd(OP_GET, pick_word(), 8'd2, rnd8(), rnd8());
      send_cmd(OP_GET, pick_word(), 8'd6, rnd8(), rnd8());
      send_cmd(OP_GET, pick_word(), 8'd255, rnd8(), rnd8());
      send_cmd(OP_MAX, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_MIN, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_APPEND, WORD_MOST_POS, rnd8(), rnd8(), rnd8());
      // this sum wraps past the top of the word
      send_cmd(OP_SUM, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_LSEARCH, WORD_MOST_POS, rnd8(), rnd8(), rnd8());
      send_cmd(OP_LSEARCH, 32'sd12345, rnd8(), rnd8(), rnd8());
      send_cmd(OP_REVERSE, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_REMOVE, pick_word(), 8'd6, rnd8(), rnd8());
      send_cmd(OP_REVERSE, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_REMOVE, pick_word(), 8'd0, rnd8(), rnd8());
      send_cmd(OP_REMOVE, pick_word(), 8'd200, rnd8(), rnd8());
      // unsorted contents still follow the halving probes
      send_cmd(OP_BSEARCH, WORD_MOST_POS, rnd8(), 8'd0, 8'd255);
   endtask

   task automatic test_capacity_limits();
      empty_list();
      // zero capacity: nothing fits
      write_capacity(9'd0);
      send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_INSERT, pick_word(), 8'd0, rnd8(), rnd8());
      write_capacity(9'd1);
      send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_INSERT, pick_word(), 8'd200, rnd8(), rnd8());
      write_capacity(9'd3);
      send_cmd(OP_APPEND, 32'sd10, rnd8(), rnd8(), rnd8());
      send_cmd(OP_APPEND, 32'sd20, rnd8(), rnd8(), rnd8());
      // lower the capacity under the count: entries stay, growth is refused
      write_capacity(9'd2);
      send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_INSERT, pick_word(), 8'd1, rnd8(), rnd8());
      send_cmd(OP_REMOVE, pick_word(), 8'd0, rnd8(), rnd8());
      send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_GET, pick_word(), 8'd1, rnd8(), rnd8());
      // range start above the clipped end, then a clipped full range
      send_cmd(OP_BSEARCH, 32'sd20, rnd8(), 8'd200, 8'd255);
      send_cmd(OP_BSEARCH, 32'sd20, rnd8(), 8'd0, 8'd255);
      write_capacity(9'd511);
      send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
   endtask

   task automatic test_random_edits(input int n);
      for (int k = 0; k < n; k++) begin
         if (k % 75 == 0) write_capacity(pick_capacity());
         send_random_edit();
      end
   endtask

   // Build ascending lists, now and then reversed, and probe them with keys that mostly hit.
   task automatic test_sorted_search(input int rounds);
      int                 n;
      int                 lo;
      int                 hi;
      longint             span;
      longint             cur;
      logic signed [31:0] key;
      logic [3:0]         op;
      for (int r = 0; r < rounds; r++) begin
         write_capacity(9'($urandom_range(8, 48)));
         empty_list();
         n    = $urandom_range(1, int'(shadow_capacity));
         span = longint'(n) * (longint'(1) << 24);
         cur  = -64'sd2147483648 + longint'($urandom_range(0, 32'(64'd4294967295 - span)));
         for (int j = 0; j < n; j++) begin
            send_cmd(OP_APPEND, 32'(cur), rnd8(), rnd8(), rnd8());
            cur += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 24);
         end
         if ($urandom_range(0, 3) == 0) send_cmd(OP_REVERSE, pick_word(), rnd8(), rnd8(), rnd8());
         for (int j = 0; j < 25; j++) begin
            key = shadow_words[$urandom_range(0, shadow_count - 1)];
            case ($urandom_range(0, 9))
               6:    key = key + 32'sd1;
               7:    key = key - 32'sd1;
               8, 9: key = 32'($urandom);
               default: ;
            endcase
            case ($urandom_range(0, 9))
               5, 6, 7: begin
                  lo = $urandom_range(0, shadow_count - 1);
                  hi = $urandom_range(lo, shadow_count - 1);
               end
               8: begin
                  lo = $urandom_range(0, 255);
                  hi = $urandom_range(0, 255);
               end
               9: begin
                  lo = 0;
                  hi = shadow_count - 1;
               end
               default: begin
                  lo = 0;
                  hi = 255;
               end
            endcase
            op = ($urandom_range(0, 5) == 0) ? OP_LSEARCH : OP_BSEARCH;
            send_cmd(op, key, rnd8(), 8'(lo), 8'(hi));
         end
      end
   endtask

   // Hold the result side for a long stretch while commands keep coming.
   task automatic test_backpressure();
      write_capacity(9'd32);
      long_hold_req = 1'b1;
      repeat (40) send_random_edit();
   endtask

   task automatic test_full_list();
      write_capacity(9'd511);
      while (shadow_count < DEPTH) begin
         if ($urandom_range(0, 9) == 0)
            send_cmd($urandom_range(0, 1) ? OP_GET : OP_LSEARCH, pick_word(), pick_index(),
                     rnd8(), rnd8());
         else
            send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
      end
      send_cmd(OP_APPEND, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_INSERT, pick_word(), 8'd255, rnd8(), rnd8());
      send_cmd(OP_GET, pick_word(), 8'd255, rnd8(), rnd8());
      send_cmd(OP_SUM, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_MAX, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_MIN, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_LSEARCH, shadow_words[250], rnd8(), rnd8(), rnd8());
      send_cmd(OP_BSEARCH, shadow_words[100], rnd8(), 8'd0, 8'd255);
      send_cmd(OP_REVERSE, pick_word(), rnd8(), rnd8(), rnd8());
      send_cmd(OP_REMOVE, pick_word(), 8'd0, rnd8(), rnd8());
      send_cmd(OP_INSERT, pick_word(), 8'd0, rnd8(), rnd8());
      send_cmd(OP_REMOVE, pick_word(), 8'd255, rnd8(), rnd8());
      send_cmd(OP_GET, pick_word(), 8'd255, rnd8(), rnd8());
      empty_list();
      write_capacity(9'd256);
   endtask

   // Result side stall pattern, switching style at random between runs.
   initial begin : rsp_stall_pattern
      int mode;
      int run_left;
      mode     = 0;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            long_hold_req = 1'b0;
         end else begin
            if (run_left == 0) begin
               mode     = $urandom_range(0, 3);
               run_left = $urandom_range(20, 200);
            end
            run_left--;
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 99) < 30);
               2:       rsp_stall = ($urandom_range(0, 99) < 65);
               default: rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result: status %0d data %0d found %0d count %0d",
                                   rsp_status, rsp_data_out, rsp_found_index, rsp_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_data_out !== want.data ||
                rsp_found_index !== want.found || rsp_count !== want.count)
               note_failure($sformatf({"op %0d: expected status %0d data %0d found %0d ",
                                       "count %0d, got status %0d data %0d found %0d count %0d"},
                                      want.op, want.status, want.data, want.found, want.count,
                                      rsp_status, rsp_data_out, rsp_found_index, rsp_count));
         end
      end
   end

   initial begin : run_tests
      int leftover;
      for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_list_edits();
      test_capacity_limits();
      test_random_edits(600);
      test_sorted_search(8);
      test_backpressure();
      test_full_list();

      wait_idle();
      leftover = pending_results.size();
      if (leftover > 0) begin
         fail_count += leftover;
         $display("%0t: %0d results never arrived", $time, leftover);
      end
      if (fail_count == 0)
         $display("array_table_engine_core verification clean");
      else
         $display("array_table_engine_core verification failed");
      $finish;
   end

endmodule
